[src/rbqe_pkg.sv]
// Package for the rotated billboard quad expander: widths, stage payload type
// and the quarter-turn sine/cosine tables built at elaboration.
// No dependencies; used by the top level, both checkers and the testbench top.
`timescale 1ns / 1ps

package rbqe_pkg;

  // Field widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned OFS_W   = 18;
  localparam int unsigned VN_W    = 12;

  // Particle counter
  localparam int unsigned MAX_PARTICLES = 1024;
  localparam int unsigned CAP   = (MAX_PARTICLES > 1024) ? 1024 : MAX_PARTICLES;
  localparam int unsigned CNT_W = (CAP > 1) ? $clog2(CAP) : 1;

  // Sine table: power-of-two phase count, folded to one quarter turn
  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned PHASE_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned QTR_W     = PHASE_W - 2;
  localparam int unsigned QTR_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam int unsigned Q14_W     = 15;   // 0 .. 16384
  localparam int unsigned FAC_W     = 17;   // c-s and s+c, signed
  localparam int unsigned PROD_W    = 34;

  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [QTR_DEPTH-1:0][Q14_W-1:0] qtab_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [COLOR_W-1:0]      color;
    logic [SIZE_W-1:0]       size;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } part_t;

  // Divisor of Taylor step i: a*(a+1), a = 2i for sine, 2i-1 for cosine.
  function automatic longint unsigned series_div(input int i, input logic want_sin);
    longint unsigned a;
    a = want_sin ? longint'(2 * i) : longint'(2 * i - 1);
    return a * (a + 64'd1);
  endfunction

  // Restoring long division; only ever evaluated while the tables are built.
  function automatic longint unsigned long_div(input longint unsigned num,
                                               input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One quarter-turn entry in Q1.14, 8-term series in Q30, rounded half up.
  function automatic logic [Q14_W-1:0] quarter_entry(input int unsigned idx,
                                                     input logic want_sin);
    longint unsigned r30;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint unsigned rnd;
    longint          sum;
    r30  = 64'(idx) << (32 - PHASE_W);
    x    = (r30 * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = want_sin ? x : Q30_ONE;
    sum  = signed'(term);
    for (int i = 1; i <= 7; i++) begin
      dv   = series_div(i, want_sin);
      term = long_div((term * x2) >> 30, dv);
      if ((i & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > signed'(Q30_ONE)) sum = signed'(Q30_ONE);
    rnd = (unsigned'(sum) + 64'd32768) >> 16;
    return Q14_W'(rnd);
  endfunction

  function automatic qtab_t build_qtab(input logic want_sin);
    qtab_t t;
    for (int unsigned idx = 0; idx < QTR_DEPTH; idx++) begin
      t[idx] = quarter_entry(idx, want_sin);
    end
    return t;
  endfunction

  localparam qtab_t SIN_QTAB = build_qtab(1'b1);
  localparam qtab_t COS_QTAB = build_qtab(1'b0);

endpackage

[src/rotated_billboard_quad_expander_top.sv]
// Rotated billboard quad expander: one particle request in, four vertices out.
// Each request passes the input, factor and vertex registers before its first vertex shows.
// One vertex per cycle on the output while out_ready_i is high; the vertex stage
// holds a quad for its four corners, so the next particle waits for the fourth.
// Reset (rst_ni low, async): pipeline empty, particle count 0, playing 1.
// Depends on rbqe_pkg.
`timescale 1ns / 1ps

module rotated_billboard_quad_expander_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: the playing register
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  // particle requests
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rbqe_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [rbqe_pkg::POS_W-1:0]   pos_y_i,
  input  logic signed [rbqe_pkg::POS_W-1:0]   pos_z_i,
  input  logic [rbqe_pkg::COLOR_W-1:0]        tint_i,
  input  logic [rbqe_pkg::SIZE_W-1:0]         half_extent_i,
  input  logic [rbqe_pkg::ANGLE_W-1:0]        angle_i,
  input  logic                                batch_end_i,
  // vertex requests
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rbqe_pkg::POS_W-1:0]   vert_x_o,
  output logic signed [rbqe_pkg::POS_W-1:0]   vert_y_o,
  output logic signed [rbqe_pkg::POS_W-1:0]   vert_z_o,
  output logic                                tex_u_o,
  output logic                                tex_v_o,
  output logic [rbqe_pkg::COLOR_W-1:0]        vert_color_o,
  output logic signed [rbqe_pkg::OFS_W-1:0]   offset_x_o,
  output logic signed [rbqe_pkg::OFS_W-1:0]   offset_y_o,
  output logic [rbqe_pkg::VN_W-1:0]           vertex_number_o,
  output logic                                quad_done_o,
  output logic                                batch_done_o
);
  import rbqe_pkg::*;

  // Quadrant of the phase
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Corner index within the quad
  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;
  localparam logic [1:0] CORNER_3 = 2'd3;

  localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(CAP - 1);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(8192);

  // Control state
  logic             playing_q;
  logic [CNT_W-1:0] particle_count_q, particle_count_d;
  logic             s1_valid_q, s1_valid_d;
  logic             s2_valid_q, s2_valid_d;
  logic             s3_valid_q, s3_valid_d;
  logic [1:0]       s3_k_q, s3_k_d;

  // Stage payloads
  part_t                   s1_part_q, s2_part_q, s3_part_q;
  logic [ANGLE_W-1:0]      s1_angle_q;
  logic signed [FAC_W-1:0] s2_cms_q, s2_spc_q, cms_d, spc_d;
  logic signed [OFS_W-1:0] s3_vx_q, s3_vy_q, vx_d, vy_d;

  // Handshake
  logic s3_last_vtx, s3_fire, s3_ready, s2_ready, s1_ready;
  logic in_fire, take, s1_adv, s2_adv;

  // The vertex stage frees only once its fourth corner has been taken; the
  // earlier stages stay elastic so a new particle can enter meanwhile.
  assign s3_last_vtx = (s3_k_q == CORNER_3);
  assign s3_fire     = s3_valid_q & out_ready_i;
  assign s3_ready    = ~s3_valid_q | (out_ready_i & s3_last_vtx);
  assign s2_ready    = ~s2_valid_q | s3_ready;
  assign s1_ready    = ~s1_valid_q | s2_ready;
  assign in_ready_o  = s1_ready;
  assign in_fire     = in_valid_i & s1_ready;
  // While not playing, requests are taken and dropped.
  assign take        = in_fire & playing_q;
  assign s1_adv      = s1_valid_q & s2_ready;
  assign s2_adv      = s2_valid_q & s3_ready;

  assign s1_valid_d = take | (s1_valid_q & ~s2_ready);
  assign s2_valid_d = s1_adv | (s2_valid_q & ~s3_ready);
  assign s3_valid_d = s2_adv | (s3_valid_q & ~(out_ready_i & s3_last_vtx));

  always_comb begin
    s3_k_d = s3_k_q;
    if (s2_adv) begin
      s3_k_d = CORNER_0;
    end else if (s3_fire) begin
      s3_k_d = s3_k_q + 2'd1;
    end
  end

  // Particle index within the batch: saturates at CAP-1, cleared by batch end
  always_comb begin
    particle_count_d = particle_count_q;
    if (take) begin
      if (batch_end_i) begin
        particle_count_d = '0;
      end else if (particle_count_q != CAP_LAST) begin
        particle_count_d = particle_count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q        <= 1'b1;
      particle_count_q <= '0;
      s1_valid_q       <= 1'b0;
      s2_valid_q       <= 1'b0;
      s3_valid_q       <= 1'b0;
      s3_k_q           <= CORNER_0;
    end else begin
      if (cfg_we_i) begin
        playing_q <= cfg_wdata_i;
      end
      particle_count_q <= particle_count_d;
      s1_valid_q       <= s1_valid_d;
      s2_valid_q       <= s2_valid_d;
      s3_valid_q       <= s3_valid_d;
      s3_k_q           <= s3_k_d;
    end
  end

  // Stage 1: input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_part_q.pos_x <= pos_x_i;
      s1_part_q.pos_y <= pos_y_i;
      s1_part_q.pos_z <= pos_z_i;
      s1_part_q.color <= tint_i;
      s1_part_q.size  <= half_extent_i;
      s1_part_q.count <= particle_count_q;
      s1_part_q.last  <= batch_end_i;
      s1_angle_q      <= angle_i;
    end
  end

  // Stage 1 -> 2: quarter-table lookup, quadrant fold, rotation factors
  logic [PHASE_W-1:0]      phase;
  logic [1:0]              quad;
  logic [QTR_W-1:0]        qidx;
  logic signed [15:0]      sv, cv, sin_s, cos_s;

  assign phase = s1_angle_q[ANGLE_W-1 -: PHASE_W];
  assign quad  = phase[PHASE_W-1 -: 2];
  assign qidx  = phase[QTR_W-1:0];
  assign sv    = $signed({1'b0, SIN_QTAB[qidx]});
  assign cv    = $signed({1'b0, COS_QTAB[qidx]});

  always_comb begin
    case (quad)
      QUAD_0: begin
        sin_s = sv;
        cos_s = cv;
      end
      QUAD_1: begin
        sin_s = cv;
        cos_s = -sv;
      end
      QUAD_2: begin
        sin_s = -sv;
        cos_s = -cv;
      end
      QUAD_3: begin
        sin_s = -cv;
        cos_s = sv;
      end
      default: begin
        sin_s = sv;
        cos_s = cv;
      end
    endcase
  end

  assign cms_d = FAC_W'(cos_s) - FAC_W'(sin_s);
  assign spc_d = FAC_W'(sin_s) + FAC_W'(cos_s);

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_part_q <= s1_part_q;
      s2_cms_q  <= cms_d;
      s2_spc_q  <= spc_d;
    end
  end

  // Stage 2 -> 3: size times factor, +0.5 and floor shift by 14.
  // The result always fits the 18 bit offset range, so no clamp is needed.
  logic signed [FAC_W-1:0]  size_s;
  logic signed [PROD_W-1:0] prod_x, prod_y, rnd_x, rnd_y;

  assign size_s = $signed({1'b0, s2_part_q.size});
  assign prod_x = size_s * s2_cms_q;
  assign prod_y = size_s * s2_spc_q;
  assign rnd_x  = prod_x + ROUND_HALF;
  assign rnd_y  = prod_y + ROUND_HALF;
  assign vx_d   = rnd_x[OFS_W+13:14];
  assign vy_d   = rnd_y[OFS_W+13:14];

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      s3_part_q <= s2_part_q;
      s3_vx_q   <= vx_d;
      s3_vy_q   <= vy_d;
    end
  end

  // Stage 3: corner sequencer. Offsets are -v, (vy,-vx), v, (-vy,vx).
  always_comb begin
    case (s3_k_q)
      CORNER_0: begin
        offset_x_o = -s3_vx_q;
        offset_y_o = -s3_vy_q;
        tex_u_o    = 1'b0;
        tex_v_o    = 1'b0;
      end
      CORNER_1: begin
        offset_x_o = s3_vy_q;
        offset_y_o = -s3_vx_q;
        tex_u_o    = 1'b1;
        tex_v_o    = 1'b0;
      end
      CORNER_2: begin
        offset_x_o = s3_vx_q;
        offset_y_o = s3_vy_q;
        tex_u_o    = 1'b1;
        tex_v_o    = 1'b1;
      end
      CORNER_3: begin
        offset_x_o = -s3_vy_q;
        offset_y_o = s3_vx_q;
        tex_u_o    = 1'b0;
        tex_v_o    = 1'b1;
      end
      default: begin
        offset_x_o = s3_vx_q;
        offset_y_o = s3_vy_q;
        tex_u_o    = 1'b0;
        tex_v_o    = 1'b0;
      end
    endcase
  end

  assign out_valid_o     = s3_valid_q;
  assign vert_x_o        = s3_part_q.pos_x;
  assign vert_y_o        = s3_part_q.pos_y;
  assign vert_z_o        = s3_part_q.pos_z;
  assign vert_color_o    = s3_part_q.color;
  // 4*count + corner never passes 4*CAP-1, so no clamp here either
  assign vertex_number_o = VN_W'({s3_part_q.count, s3_k_q});
  assign quad_done_o     = s3_last_vtx;
  assign batch_done_o    = s3_last_vtx & s3_part_q.last;

endmodule

[src/rbqe_checker.sv]
// Port-level checker for the quad expander, bound to the top level.
// Depends on rbqe_pkg and rotated_billboard_quad_expander_top.
`timescale 1ns / 1ps

module rbqe_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [rbqe_pkg::POS_W-1:0]   vert_x_o,
  input logic                                tex_u_o,
  input logic                                tex_v_o,
  input logic [rbqe_pkg::COLOR_W-1:0]        vert_color_o,
  input logic signed [rbqe_pkg::OFS_W-1:0]   offset_x_o,
  input logic signed [rbqe_pkg::OFS_W-1:0]   offset_y_o,
  input logic [rbqe_pkg::VN_W-1:0]           vertex_number_o,
  input logic                                quad_done_o,
  input logic                                batch_done_o
);
  import rbqe_pkg::*;

  logic vtx_taken_mid;
  assign vtx_taken_mid = out_valid_o && out_ready_i && !quad_done_o;

  // Stalled vertex holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(offset_x_o)
      && $stable(offset_y_o) && $stable(vertex_number_o))
    else $error("stalled vertex changed");

  // The rest of a quad follows at once with the next vertex number
  a_quad_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_taken_mid |=> out_valid_o
      && vertex_number_o == VN_W'($past(vertex_number_o) + VN_W'(1)))
    else $error("quad vertex missing or misnumbered");

  // Each corner is the previous one turned a quarter, same particle
  a_corner_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_taken_mid |=> OFS_W'(offset_x_o + $past(offset_y_o)) == OFS_W'(0)
      && offset_y_o == $past(offset_x_o) && $stable(vert_x_o)
      && $stable(vert_color_o))
    else $error("corner offsets not a quarter-turn apart");

  // Batch end only on the closing corner (0,1)
  a_batch_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && batch_done_o |-> quad_done_o && tex_v_o && !tex_u_o)
    else $error("batch end off the closing corner");

endmodule

bind rotated_billboard_quad_expander_top rbqe_checker u_rbqe_checker (.*);

[tb/sv/quad_vertex_checker.sv]
// Vertex checker for the rotated billboard quad expander: tracks the playing
// register and the particle requests, predicts each quad and compares vertices.
// Depends on rbqe_pkg for field widths and sizing parameters.
`timescale 1ns / 1ps

module quad_vertex_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [rbqe_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [rbqe_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [rbqe_pkg::POS_W-1:0] pos_z_i,
  input  logic [rbqe_pkg::COLOR_W-1:0]      tint_i,
  input  logic [rbqe_pkg::SIZE_W-1:0]       half_extent_i,
  input  logic [rbqe_pkg::ANGLE_W-1:0]      angle_i,
  input  logic                              batch_end_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [rbqe_pkg::POS_W-1:0] vert_x_i,
  input  logic signed [rbqe_pkg::POS_W-1:0] vert_y_i,
  input  logic signed [rbqe_pkg::POS_W-1:0] vert_z_i,
  input  logic                              tex_u_i,
  input  logic                              tex_v_i,
  input  logic [rbqe_pkg::COLOR_W-1:0]      vert_color_i,
  input  logic signed [rbqe_pkg::OFS_W-1:0] offset_x_i,
  input  logic signed [rbqe_pkg::OFS_W-1:0] offset_y_i,
  input  logic [rbqe_pkg::VN_W-1:0]         vertex_number_i,
  input  logic                              quad_done_i,
  input  logic                              batch_done_i,
  output int unsigned                       pending_o,
  output int unsigned                       fail_count_o,
  output int unsigned                       checked_o
);

  localparam int unsigned PHASES    = rbqe_pkg::SINE_TABLE_DEPTH;
  localparam int unsigned COUNT_CAP =
    (rbqe_pkg::MAX_PARTICLES > 1024) ? 1024 :
    (rbqe_pkg::MAX_PARTICLES < 1)    ? 1    : rbqe_pkg::MAX_PARTICLES;
  localparam longint unsigned ONE_Q30      = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30X = 64'd1686629713;  // pi/2 in Q30

  typedef struct {
    logic signed [rbqe_pkg::POS_W-1:0] x;
    logic signed [rbqe_pkg::POS_W-1:0] y;
    logic signed [rbqe_pkg::POS_W-1:0] z;
    logic                              u;
    logic                              v;
    logic [rbqe_pkg::COLOR_W-1:0]      color;
    logic signed [rbqe_pkg::OFS_W-1:0] ofs_x;
    logic signed [rbqe_pkg::OFS_W-1:0] ofs_y;
    logic [rbqe_pkg::VN_W-1:0]         vnum;
    logic                              quad_last;
    logic                              batch_last;
  } vertex_t;

  vertex_t     expected_vertices[$];
  logic        playing;
  int unsigned particle_index;
  int unsigned fails   = 0;
  int unsigned checked = 0;

  // 8-term Taylor series in Q30 over 0..pi/2, clamped to 0..1
  function automatic longint taylor_q30(input longint unsigned x, input bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned a;
    longint          acc;
    int              i;
    x2   = (x * x) >> 30;
    term = odd ? x : ONE_Q30;
    acc  = $signed(term);
    for (i = 1; i <= 7; i++) begin
      a    = odd ? longint'(2 * i) : longint'(2 * i - 1);
      term = ((term * x2) >> 30) / (a * (a + 1));
      if (i % 2 == 1) acc -= $signed(term);
      else acc += $signed(term);
    end
    if (acc < 0) acc = 0;
    if (acc > $signed(ONE_Q30)) acc = $signed(ONE_Q30);
    return acc;
  endfunction

  // quantise angle to a table phase, fold into the first quadrant, unfold
  function automatic void turn_sin_cos(input logic [rbqe_pkg::ANGLE_W-1:0] angle,
                                       output int s, output int c);
    longint unsigned phase;
    longint unsigned turn_frac;
    longint unsigned rem;
    longint unsigned x;
    int              sv;
    int              cv;
    phase     = (64'(angle) * PHASES) >> 16;
    turn_frac = (phase << 32) / PHASES;
    rem       = turn_frac & 64'h3FFF_FFFF;
    x         = (rem * HALF_PI_Q30X) >> 30;
    sv        = int'((taylor_q30(x, 1'b1) + 32768) >>> 16);
    cv        = int'((taylor_q30(x, 1'b0) + 32768) >>> 16);
    case (turn_frac[31:30])
      2'd0: begin
        s = sv;  c = cv;
      end
      2'd1: begin
        s = cv;  c = -sv;
      end
      2'd2: begin
        s = -sv; c = -cv;
      end
      default: begin
        s = -cv; c = sv;
      end
    endcase
  endfunction

  // size (Q8.8) times a Q1.14 factor, rounded with a floor shift, saturated
  function automatic int scale_q14(input logic [rbqe_pkg::SIZE_W-1:0] size,
                                   input int factor);
    longint t;
    t = longint'(size) * factor + 8192;
    t = t >>> 14;
    if (t > 131071) t = 131071;
    if (t < -131072) t = -131072;
    return int'(t);
  endfunction

  function automatic void expand_quad(input logic signed [rbqe_pkg::POS_W-1:0] px,
                                      input logic signed [rbqe_pkg::POS_W-1:0] py,
                                      input logic signed [rbqe_pkg::POS_W-1:0] pz,
                                      input logic [rbqe_pkg::COLOR_W-1:0] color,
                                      input logic [rbqe_pkg::SIZE_W-1:0] size,
                                      input logic [rbqe_pkg::ANGLE_W-1:0] angle,
                                      input logic last);
    int          s;
    int          c;
    int          vx;
    int          vy;
    int          k;
    int          ox[4];
    int          oy[4];
    int unsigned idx;
    int unsigned vnum;
    vertex_t     vtx;
    turn_sin_cos(angle, s, c);
    vx  = scale_q14(size, c - s);
    vy  = scale_q14(size, s + c);
    ox  = '{-vx, vy, vx, -vy};
    oy  = '{-vy, -vx, vy, vx};
    idx = (particle_index > COUNT_CAP - 1) ? COUNT_CAP - 1 : particle_index;
    for (k = 0; k < 4; k++) begin
      vnum = 4 * idx + k;
      if (vnum > 4 * COUNT_CAP - 1) vnum = 4 * COUNT_CAP - 1;
      vtx.x          = px;
      vtx.y          = py;
      vtx.z          = pz;
      vtx.u          = (k == 1 || k == 2);
      vtx.v          = (k >= 2);
      vtx.color      = color;
      vtx.ofs_x      = rbqe_pkg::OFS_W'(ox[k]);
      vtx.ofs_y      = rbqe_pkg::OFS_W'(oy[k]);
      vtx.vnum       = vnum[rbqe_pkg::VN_W-1:0];
      vtx.quad_last  = (k == 3);
      vtx.batch_last = (k == 3) && last;
      expected_vertices.push_back(vtx);
    end
    if (last) particle_index = 0;
    else if (particle_index < COUNT_CAP - 1) particle_index++;
  endfunction

  function automatic void match_field(input string field, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    vertex_t want;
    if (!rst_ni) begin
      expected_vertices.delete();
      playing        = 1'b1;
      particle_index = 0;
    end else begin
      // a vertex never leaves in the cycle its particle is taken
      if (out_valid_i && out_ready_i) begin
        if (expected_vertices.size() == 0) begin
          $error("vertex_number: expected no vertex, got %0d", vertex_number_i);
          fails++;
        end else begin
          want = expected_vertices.pop_front();
          match_field("vert_x", want.x, vert_x_i);
          match_field("vert_y", want.y, vert_y_i);
          match_field("vert_z", want.z, vert_z_i);
          match_field("tex_u", want.u, tex_u_i);
          match_field("tex_v", want.v, tex_v_i);
          match_field("vert_color", want.color, vert_color_i);
          match_field("offset_x", want.ofs_x, offset_x_i);
          match_field("offset_y", want.ofs_y, offset_y_i);
          match_field("vertex_number", want.vnum, vertex_number_i);
          match_field("quad_done", want.quad_last, quad_done_i);
          match_field("batch_done", want.batch_last, batch_done_i);
          checked++;
        end
      end
      if (in_valid_i && in_ready_i && playing) begin
        expand_quad(pos_x_i, pos_y_i, pos_z_i, tint_i, half_extent_i, angle_i, batch_end_i);
      end
      if (cfg_we_i) playing = cfg_wdata_i;
    end
    pending_o    <= expected_vertices.size();
    fail_count_o <= fails;
    checked_o    <= checked;
  end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the rotated billboard quad expander: clock, reset, particle
// and vertex traffic, the playing register and the verdict.
// Depends on rbqe_pkg, rotated_billboard_quad_expander_top and quad_vertex_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned SETTLE_CYCLES    = 8;     // settling margin after the last vertex
  localparam int unsigned HOLD_OFF_CYCLES  = 80;
  localparam int unsigned RANDOM_PER_PHASE = 38;
  localparam bit          EMITTER_ON       = 1'b1;
  localparam bit          EMITTER_OFF      = 1'b0;

  // idling plan per random phase: none, sender idle, receiver stalling, both
  localparam int unsigned IDLE_PLAN[4]  = '{0, 73, 0, 36};
  localparam int unsigned STALL_PLAN[4] = '{0, 0, 73, 36};

  typedef struct {
    logic signed [rbqe_pkg::POS_W-1:0] px;
    logic signed [rbqe_pkg::POS_W-1:0] py;
    logic signed [rbqe_pkg::POS_W-1:0] pz;
    logic [rbqe_pkg::COLOR_W-1:0]      color;
    logic [rbqe_pkg::SIZE_W-1:0]       size;
    logic [rbqe_pkg::ANGLE_W-1:0]      angle;
    logic                              last;
  } particle_t;

  logic                              clk_i;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_we_i      = 1'b0;
  logic                              cfg_wdata_i   = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic signed [rbqe_pkg::POS_W-1:0] pos_x_i       = '0;
  logic signed [rbqe_pkg::POS_W-1:0] pos_y_i       = '0;
  logic signed [rbqe_pkg::POS_W-1:0] pos_z_i       = '0;
  logic [rbqe_pkg::COLOR_W-1:0]      tint_i        = '0;
  logic [rbqe_pkg::SIZE_W-1:0]       half_extent_i = '0;
  logic [rbqe_pkg::ANGLE_W-1:0]      angle_i       = '0;
  logic                              batch_end_i   = 1'b0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  logic signed [rbqe_pkg::POS_W-1:0] vert_x_o;
  logic signed [rbqe_pkg::POS_W-1:0] vert_y_o;
  logic signed [rbqe_pkg::POS_W-1:0] vert_z_o;
  logic                              tex_u_o;
  logic                              tex_v_o;
  logic [rbqe_pkg::COLOR_W-1:0]      vert_color_o;
  logic signed [rbqe_pkg::OFS_W-1:0] offset_x_o;
  logic signed [rbqe_pkg::OFS_W-1:0] offset_y_o;
  logic [rbqe_pkg::VN_W-1:0]         vertex_number_o;
  logic                              quad_done_o;
  logic                              batch_done_o;

  int unsigned pending_verts;
  int unsigned fail_count;
  int unsigned checked_verts;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned offered        = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_off_reqs  = 0;

  rotated_billboard_quad_expander_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .tint_i          (tint_i),
    .half_extent_i   (half_extent_i),
    .angle_i         (angle_i),
    .batch_end_i     (batch_end_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .vert_x_o        (vert_x_o),
    .vert_y_o        (vert_y_o),
    .vert_z_o        (vert_z_o),
    .tex_u_o         (tex_u_o),
    .tex_v_o         (tex_v_o),
    .vert_color_o    (vert_color_o),
    .offset_x_o      (offset_x_o),
    .offset_y_o      (offset_y_o),
    .vertex_number_o (vertex_number_o),
    .quad_done_o     (quad_done_o),
    .batch_done_o    (batch_done_o)
  );

  // the checker sees exactly what the block sees; it owns prediction and compare
  quad_vertex_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .tint_i          (tint_i),
    .half_extent_i   (half_extent_i),
    .angle_i         (angle_i),
    .batch_end_i     (batch_end_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .vert_x_i        (vert_x_o),
    .vert_y_i        (vert_y_o),
    .vert_z_i        (vert_z_o),
    .tex_u_i         (tex_u_o),
    .tex_v_i         (tex_v_o),
    .vert_color_i    (vert_color_o),
    .offset_x_i      (offset_x_o),
    .offset_y_i      (offset_y_o),
    .vertex_number_i (vertex_number_o),
    .quad_done_i     (quad_done_o),
    .batch_done_i    (batch_done_o),
    .pending_o       (pending_verts),
    .fail_count_o    (fail_count),
    .checked_o       (checked_verts)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Vertex receiver. Random stalls per the current phase; on request from the
  // stimulus it holds ready low for a long, self-counted stretch so that the
  // block backs up and has to refuse particle requests.
  initial begin : receiver
    int unsigned hold_off_seen;
    hold_off_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_reqs != hold_off_seen) begin
        hold_off_seen = hold_off_reqs;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic particle_t make_particle(input logic [31:0] px, input logic [31:0] py,
                                              input logic [31:0] pz, input logic [31:0] color,
                                              input logic [15:0] size, input logic [15:0] angle,
                                              input logic last);
    particle_t p;
    p.px    = px;
    p.py    = py;
    p.pz    = pz;
    p.color = color;
    p.size  = size;
    p.angle = angle;
    p.last  = last;
    return p;
  endfunction

  // Half full-range sizes, a quarter tiny sizes and a quarter the two extremes, so
  // the rounding near zero and the largest offsets both get traffic.
  function automatic particle_t random_particle(input bit hold_batch);
    particle_t p;
    p.px    = $urandom;
    p.py    = $urandom;
    p.pz    = $urandom;
    p.color = $urandom;
    case ($urandom_range(3))
      0:       p.size = rbqe_pkg::SIZE_W'($urandom_range(15));
      1:       p.size = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: p.size = rbqe_pkg::SIZE_W'($urandom);
    endcase
    p.angle = rbqe_pkg::ANGLE_W'($urandom);
    p.last  = hold_batch ? 1'b0 : ($urandom_range(7) == 0);
    return p;
  endfunction

  // Offer one particle request; valid stays up until the block takes it and is
  // only dropped when an idle gap follows, never pulsed within one step.
  task automatic offer_particle(input particle_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pos_x_i       <= p.px;
    pos_y_i       <= p.py;
    pos_z_i       <= p.pz;
    tint_i        <= p.color;
    half_extent_i <= p.size;
    angle_i       <= p.angle;
    batch_end_i   <= p.last;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    offered++;
  endtask

  // Sender pause: wait for every predicted vertex, then let the pipeline settle
  // (a dropped request while not playing leaves nothing to wait for).
  task automatic drain_vertices();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_verts != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_playing(input bit on);
    drain_vertices();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : stimulus
    particle_t   p;
    int unsigned ph;
    int unsigned n;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_playing(EMITTER_ON);

    // Directed: field extremes, quadrant edges and diagonals, phase rounding.
    offer_particle(make_particle(32'h0, 32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 1'b0));
    offer_particle(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                 16'hFFFF, 16'h0000, 1'b0));
    offer_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                                 16'hFFFF, 16'h4000, 1'b0));
    offer_particle(make_particle(32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h1234_5678,
                                 16'hFFFF, 16'h8000, 1'b0));
    offer_particle(make_particle(32'h0000_0001, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'hA5A5_5A5A,
                                 16'hFFFF, 16'hC000, 1'b0));
    offer_particle(make_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'hFFFF_FFFF,
                                 16'hFFFF, 16'hFFFF, 1'b0));
    // just under and on the first table step
    offer_particle(make_particle(32'h1, 32'h2, 32'h3, 32'h0000_00FF, 16'h0001, 16'h003F, 1'b0));
    offer_particle(make_particle(32'h4, 32'h5, 32'h6, 32'hFF00_0000, 16'h0100, 16'h0040, 1'b0));
    // either side of the quarter turn
    offer_particle(make_particle(32'h7, 32'h8, 32'h9, 32'h0F0F_0F0F, 16'hFFFF, 16'h3FFF, 1'b0));
    offer_particle(make_particle(32'hA, 32'hB, 32'hC, 32'hF0F0_F0F0, 16'hFFFF, 16'h4040, 1'b0));
    // diagonals, where one offset component collapses to zero
    offer_particle(make_particle(32'hD, 32'hE, 32'hF, 32'h0, 16'hFFFF, 16'h2000, 1'b0));
    offer_particle(make_particle(32'h10, 32'h11, 32'h12, 32'h1, 16'hFFFF, 16'h6000, 1'b0));
    offer_particle(make_particle(32'h13, 32'h14, 32'h15, 32'h2, 16'hFFFF, 16'hA000, 1'b0));
    offer_particle(make_particle(32'h16, 32'h17, 32'h18, 32'h3, 16'hFFFF, 16'hE000, 1'b0));
    // batch end: vertex numbering restarts on the next particle
    offer_particle(make_particle(32'h19, 32'h1A, 32'h1B, 32'h4, 16'h8000, 16'h1234, 1'b1));
    offer_particle(make_particle(32'h1C, 32'h1D, 32'h1E, 32'h5, 16'h00FF, 16'h5555, 1'b0));
    offer_particle(make_particle(32'h1F, 32'h20, 32'h21, 32'h6, 16'h0001, 16'hAAAA, 1'b0));

    // Not playing: requests dropped, batch end ignored, count left alone.
    write_playing(EMITTER_OFF);
    for (n = 0; n < 3; n++) begin
      p      = random_particle(1'b0);
      p.last = (n != 1);
      offer_particle(p);
    end
    write_playing(EMITTER_ON);
    offer_particle(make_particle(32'h22, 32'h23, 32'h24, 32'h7, 16'hFFFF, 16'h7FFF, 1'b0));
    offer_particle(make_particle(32'h25, 32'h26, 32'h27, 32'h8, 16'h0080, 16'h8001, 1'b1));

    // Random phases under the idling plan.
    for (ph = 0; ph < 4; ph++) begin
      drain_vertices();
      send_idle_pct  = IDLE_PLAN[ph];
      recv_stall_pct = STALL_PLAN[ph];
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        // long receiver hold-off while requests keep coming
        if (ph == 0 && n == 10) hold_off_reqs++;
        // sender pause mid-phase until every vertex is home
        if (n == RANDOM_PER_PHASE / 2) drain_vertices();
        offer_particle(random_particle(1'b0));
      end
      if (ph == 1) begin
        write_playing(EMITTER_OFF);
        for (n = 0; n < 8; n++) offer_particle(random_particle(1'b0));
        write_playing(EMITTER_ON);
      end
    end

    drain_vertices();
    $display("Run covered %0d particle requests and %0d checked vertices across four idling",
             offered, checked_verts);
    $display("phases, playing on and off, batch restarts and a long output hold-off.");
    if (fail_count == 0 && pending_verts == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[rotated_billboard_quad_expander_top.f]
src/rbqe_pkg.sv
src/rotated_billboard_quad_expander_top.sv
src/rbqe_checker.sv
tb/sv/quad_vertex_checker.sv
tb/sv/tb_top.sv
